// ===== rtl/core/mdio_prm_pkg.sv =====
// shared types and constants for the mdio phy register model
// no dependencies
package mdio_prm_pkg;

  // access codes
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;
  localparam logic TARGET_DATA = 1'b0;
  localparam logic TARGET_CTRL = 1'b1;

  // phy register addresses
  localparam logic [4:0] PHY_BMCR    = 5'h00;
  localparam logic [4:0] PHY_BMSR    = 5'h01;
  localparam logic [4:0] PHY_ID1     = 5'h02;
  localparam logic [4:0] PHY_ID2     = 5'h03;
  localparam logic [4:0] PHY_ANAR    = 5'h04;
  localparam logic [4:0] PHY_ANLPAR  = 5'h05;
  localparam logic [4:0] PHY_VENDOR  = 5'h1F;

  // phy register defaults
  localparam logic [15:0] DEF_BMCR   = 16'h3100;
  localparam logic [15:0] DEF_BMSR   = 16'h786D;
  localparam logic [15:0] DEF_ID1    = 16'h0040;
  localparam logic [15:0] DEF_ID2    = 16'h61E0;
  localparam logic [15:0] DEF_ANAR   = 16'h01E1;
  localparam logic [15:0] DEF_ANLPAR = 16'h01E1;
  localparam logic [15:0] DEF_VENDOR = 16'h000B;

  // bit masks
  localparam logic [15:0] BMCR_RESET_BIT = 16'h8000;
  localparam logic [15:0] VENDOR_WR_BIT  = 16'h0080;
  localparam int          CTL_WRITE_POS  = 10;
  localparam logic [31:0] CTL_BUSY_BIT   = 32'h0000_0800;
  localparam logic [4:0]  SEL_RESET      = 5'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // apply the item to state and register its result
  } cmd_t;

endpackage

// ===== rtl/core/mdio_phy_register_model_top.sv =====
// top level of the mdio phy register model
// depends on mdio_prm_pkg, mdio_prm_ctrl, mdio_prm_dpath

// Host-bus model of an mdio management unit with a clause 22 style phy behind
// it. Raise start with kind_i, target_i and write_data_i; the item is taken at
// the edge where start is high and busy is low. Each item gives one result,
// shown on read_data_o and phy_error_o for a single cycle while done_o is high,
// in the cycle after the execute cycle of the sequencer that follows the taking
// edge. The result cannot be held off, so catch it on that cycle. busy is high
// for the one execute cycle of the sequencer, so a new item cannot be taken
// while the previous one executes; the next item may be offered while
// done_o of the previous one is up. There is no clearing pass after reset.
module mdio_phy_register_model_top
  import mdio_prm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic        target_i,
  input  logic [31:0] write_data_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        phy_error_o
);

  // commands from the sequencer to the datapath
  cmd_t cmd;

  // sequencer: idle / execute, owns busy and the result strobe
  mdio_prm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // datapath: item latch, register state, phy rules, result registers
  mdio_prm_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .target_i     (target_i),
    .write_data_i (write_data_i),
    .read_data_o  (read_data_o),
    .phy_error_o  (phy_error_o)
  );

  // an accepted item always moves the sequencer into execute
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start execution");

  // execute lasts exactly one cycle and is followed by the strobe
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && done_o))
    else $error("execute not followed by a result strobe");

  // a strobe only follows an execute cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without an item");

  // an unmodelled phy read always reports zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && phy_error_o) |-> (read_data_o == 32'h0))
    else $error("phy error with nonzero read data");

endmodule

// ===== rtl/core/mdio_prm_ctrl.sv =====
// sequencer for the mdio phy register model
// depends on mdio_prm_pkg
module mdio_prm_ctrl
  import mdio_prm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  assign cmd_o.capture = start_i && !busy_q;
  assign cmd_o.exec    = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/mdio_prm_dpath.sv =====
// register state, phy rules and result registers of the mdio phy register model
// depends on mdio_prm_pkg
module mdio_prm_dpath
  import mdio_prm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        kind_i,
  input  logic        target_i,
  input  logic [31:0] write_data_i,
  output logic [31:0] read_data_o,
  output logic        phy_error_o
);

  // latched item
  logic        kind_q;
  logic        target_q;
  logic [31:0] wdata_q;

  // architectural state; only the writable phy registers are held
  logic [4:0]  sel_q, sel_d;
  logic [31:0] ctrl_q, ctrl_d;
  logic [31:0] data_q, data_d;
  logic [15:0] bmcr_q, bmcr_d;
  logic [15:0] anar_q, anar_d;
  logic [15:0] vend_q, vend_d;
  logic        bmcr_wr_q, bmcr_wr_d;
  logic        anar_wr_q, anar_wr_d;
  logic        vend_wr_q, vend_wr_d;

  logic [31:0] rdata_q, rdata_d;
  logic        err_q, err_d;

  logic        ctrl_wr;
  logic        phy_wr;
  logic [4:0]  idx;
  logic [15:0] vend_old;
  logic [15:0] phy_val;
  logic        phy_bad;

  always_comb begin
    ctrl_wr = (kind_q == KIND_WRITE) && (target_q == TARGET_CTRL);
    phy_wr  = ctrl_wr && wdata_q[CTL_WRITE_POS];
    idx     = ctrl_wr ? wdata_q[4:0] : sel_q;

    bmcr_d    = bmcr_q;
    anar_d    = anar_q;
    vend_d    = vend_q;
    bmcr_wr_d = bmcr_wr_q;
    anar_wr_d = anar_wr_q;
    vend_wr_d = vend_wr_q;
    vend_old  = vend_wr_q ? vend_q : DEF_VENDOR;

    // phy write with the held data word, before the refresh read
    if (phy_wr) begin
      unique case (idx)
        PHY_BMCR: begin
          bmcr_d    = data_q[15:0] & ~BMCR_RESET_BIT;
          bmcr_wr_d = 1'b1;
        end
        PHY_ANAR: begin
          anar_d    = data_q[15:0];
          anar_wr_d = 1'b1;
        end
        PHY_VENDOR: begin
          vend_d    = (vend_old & ~VENDOR_WR_BIT) | (data_q[15:0] & VENDOR_WR_BIT);
          vend_wr_d = 1'b1;
        end
        default: begin
          // read-only or unmodelled: nothing visible changes
        end
      endcase
    end

    // phy read sees the post-write values
    phy_bad = 1'b0;
    unique case (idx)
      PHY_BMCR:   phy_val = bmcr_wr_d ? bmcr_d : DEF_BMCR;
      PHY_BMSR:   phy_val = DEF_BMSR;
      PHY_ID1:    phy_val = DEF_ID1;
      PHY_ID2:    phy_val = DEF_ID2;
      PHY_ANAR:   phy_val = anar_wr_d ? anar_d : DEF_ANAR;
      PHY_ANLPAR: phy_val = DEF_ANLPAR;
      PHY_VENDOR: phy_val = vend_wr_d ? vend_d : DEF_VENDOR;
      default: begin
        phy_val = 16'h0000;
        phy_bad = 1'b1;
      end
    endcase

    sel_d   = sel_q;
    ctrl_d  = ctrl_q;
    data_d  = data_q;
    rdata_d = 32'h0;
    err_d   = 1'b0;
    unique case ({kind_q, target_q})
      {KIND_READ, TARGET_DATA}: begin
        rdata_d = {16'h0000, phy_val};
        err_d   = phy_bad;
      end
      {KIND_READ, TARGET_CTRL}: begin
        rdata_d = ctrl_q & ~CTL_BUSY_BIT;
      end
      {KIND_WRITE, TARGET_DATA}: begin
        data_d = wdata_q;
      end
      default: begin
        sel_d  = wdata_q[4:0];
        ctrl_d = wdata_q & ~CTL_BUSY_BIT;
        data_d = {16'h0000, phy_val};
        err_d  = phy_bad;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      target_q <= target_i;
      wdata_q  <= write_data_i;
    end
    if (cmd_i.exec) begin
      bmcr_q  <= bmcr_d;
      anar_q  <= anar_d;
      vend_q  <= vend_d;
      rdata_q <= rdata_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= SEL_RESET;
      ctrl_q    <= 32'h0;
      data_q    <= 32'h0;
      bmcr_wr_q <= 1'b0;
      anar_wr_q <= 1'b0;
      vend_wr_q <= 1'b0;
    end else if (cmd_i.exec) begin
      sel_q     <= sel_d;
      ctrl_q    <= ctrl_d;
      data_q    <= data_d;
      bmcr_wr_q <= bmcr_wr_d;
      anar_wr_q <= anar_wr_d;
      vend_wr_q <= vend_wr_d;
    end
  end

  assign read_data_o = rdata_q;
  assign phy_error_o = err_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for mdio_phy_register_model_top: directed and random bus accesses
// depends on mdio_prm_pkg and the rtl of mdio_phy_register_model_top

module tb_top;
  import mdio_prm_pkg::*;

  // run length and reporting
  localparam int unsigned RANDOM_ITEMS  = 830;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 8;

  // some phy addresses that have no register behind them
  localparam logic [4:0] PHY_FIRST_UNMODELLED = 5'h06;
  localparam logic [4:0] PHY_LAST_UNMODELLED  = 5'h1E;

  // one bus result as the block should show it
  typedef struct packed {
    logic [31:0] read_data;
    logic        phy_error;
  } bus_result_t;

  // a phy register read: value plus the flag for an address with nothing behind it
  typedef struct packed {
    logic        unmodelled;
    logic [15:0] value;
  } phy_read_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        kind_i       = KIND_READ;
  logic        target_i     = TARGET_DATA;
  logic [31:0] write_data_i = '0;
  logic        busy;
  logic        done_o;
  logic [31:0] read_data_o;
  logic        phy_error_o;

  // own copy of the management unit and phy state
  logic [15:0] phy_regs    [32];
  logic        phy_written [32];
  logic [4:0]  sel_reg;
  logic [31:0] ctrl_reg;
  logic [31:0] data_reg;

  // results still owed by the block, oldest first
  bus_result_t expected_results[$];

  int unsigned fail_count    = 0;
  int unsigned accesses_sent = 0;
  int unsigned burst_left    = 1;
  int unsigned cycle_count   = 0;

  mdio_phy_register_model_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .target_i     (target_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .phy_error_o  (phy_error_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop in case the block hangs or drops results
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mdio_phy_register_model_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // registers 0, 4 and 31 read back what was written, the rest of the modelled
  // set always shows its fixed value, anything else reads as zero with an error
  function automatic phy_read_t phy_lookup(input logic [4:0] idx);
    phy_read_t r;
    r.unmodelled = 1'b0;
    r.value      = '0;
    if ((idx == PHY_BMCR || idx == PHY_ANAR || idx == PHY_VENDOR) && phy_written[idx]) begin
      r.value = phy_regs[idx];
    end else begin
      case (idx)
        PHY_BMCR:   r.value = DEF_BMCR;
        PHY_BMSR:   r.value = DEF_BMSR;
        PHY_ID1:    r.value = DEF_ID1;
        PHY_ID2:    r.value = DEF_ID2;
        PHY_ANAR:   r.value = DEF_ANAR;
        PHY_ANLPAR: r.value = DEF_ANLPAR;
        PHY_VENDOR: r.value = DEF_VENDOR;
        default:    r.unmodelled = 1'b1;
      endcase
    end
    return r;
  endfunction

  // phy side write: read-only registers drop it, bmcr loses its reset bit,
  // the vendor register only takes bit 7, unmodelled addresses still store
  task automatic phy_store(input logic [4:0] idx, input logic [31:0] value);
    logic [15:0] v;
    phy_read_t   old;
    v = value[15:0];
    case (idx)
      PHY_BMSR, PHY_ID1, PHY_ID2, PHY_ANLPAR: begin
      end
      default: begin
        if (idx == PHY_BMCR) begin
          v = v & ~BMCR_RESET_BIT;
        end else if (idx == PHY_VENDOR) begin
          old = phy_lookup(idx);
          v   = (old.value & ~VENDOR_WR_BIT) | (v & VENDOR_WR_BIT);
        end
        phy_regs[idx]    = v;
        phy_written[idx] = 1'b1;
      end
    endcase
  endtask

  // apply one bus access to the predicted state and return what the block owes
  task automatic predict_bus_access(input logic kind, input logic target,
                                    input logic [31:0] wdata, output bus_result_t res);
    phy_read_t rd;
    res = '0;
    if (kind == KIND_READ) begin
      if (target == TARGET_DATA) begin
        rd            = phy_lookup(sel_reg);
        res.read_data = {16'h0000, rd.value};
        res.phy_error = rd.unmodelled;
      end else begin
        res.read_data = ctrl_reg & ~CTL_BUSY_BIT;
      end
    end else if (target == TARGET_DATA) begin
      data_reg = wdata;
    end else begin
      // control write: select, optionally push the data word, then refresh it
      sel_reg  = wdata[4:0];
      ctrl_reg = wdata & ~CTL_BUSY_BIT;
      if (wdata[CTL_WRITE_POS]) phy_store(sel_reg, data_reg);
      rd            = phy_lookup(sel_reg);
      data_reg      = {16'h0000, rd.value};
      res.phy_error = rd.unmodelled;
    end
  endtask

  function automatic void note_failure(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s expected %h got %h", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: checks results against the oldest expectation, then predicts the
  // item taken at this edge; everything is sampled at the rising edge, before
  // any of this edge's updates land
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bus_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        phy_regs[i]    = '0;
        phy_written[i] = 1'b0;
      end
      sel_reg  = SEL_RESET;
      ctrl_reg = '0;
      data_reg = '0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          note_failure("result with no access pending, read_data", '0, read_data_o);
        end else begin
          want = expected_results.pop_front();
          if (read_data_o !== want.read_data)
            note_failure("read_data", want.read_data, read_data_o);
          if (phy_error_o !== want.phy_error)
            note_failure("phy_error", 32'(want.phy_error), 32'(phy_error_o));
        end
      end
      if (start && !busy) begin
        predict_bus_access(kind_i, target_i, write_data_i, want);
        expected_results.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offer one item and hold it until taken; start stays high into the next
  // item of a burst and drops only for the gap after it
  task automatic send_access(input logic kind, input logic target, input logic [31:0] wdata);
    int unsigned gap;
    start        <= 1'b1;
    kind_i       <= kind;
    target_i     <= target;
    write_data_i <= wdata;
    do @(posedge clk_i); while (busy);
    accesses_sent++;
    burst_left--;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long run with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop offering items until every owed result has come back
  task automatic wait_for_results;
    start <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // control word that selects a phy register, with or without the write bit
  function automatic logic [31:0] ctl_word(input logic [4:0] sel, input logic push);
    logic [31:0] w;
    w                = 32'(sel);
    w[CTL_WRITE_POS] = push;
    return w;
  endfunction

  // mostly the modelled registers, sometimes any address
  function automatic logic [4:0] pick_phy_reg;
    case ($urandom_range(0, 9))
      0:       return PHY_BMCR;
      1:       return PHY_BMSR;
      2:       return PHY_ID1;
      3:       return PHY_ID2;
      4, 5:    return PHY_ANAR;
      6:       return PHY_ANLPAR;
      7:       return PHY_VENDOR;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset selects the first id register; control reads back zero
  task automatic test_reset_defaults;
    send_access(KIND_READ, TARGET_DATA, 32'hFFFF_FFFF);
    send_access(KIND_READ, TARGET_CTRL, '0);
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_BMSR, 1'b0));
    send_access(KIND_READ, TARGET_DATA, '0);
  endtask

  // all ones into bmcr: the self-clearing reset bit must not stick
  task automatic test_bmcr_write;
    send_access(KIND_WRITE, TARGET_DATA, 32'hFFFF_FFFF);
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_BMCR, 1'b1));
    send_access(KIND_READ, TARGET_DATA, '0);
  endtask

  // write to a read-only register is dropped
  task automatic test_read_only_regs;
    send_access(KIND_WRITE, TARGET_DATA, '0);
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_ANLPAR, 1'b1));
    send_access(KIND_READ, TARGET_DATA, '0);
  endtask

  // vendor register: only bit 7 follows the written value, both ways
  task automatic test_vendor_bit;
    send_access(KIND_WRITE, TARGET_DATA, 32'hFFFF_FFFF);
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_VENDOR, 1'b1));
    send_access(KIND_READ, TARGET_DATA, '0);
    send_access(KIND_WRITE, TARGET_DATA, '0);
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_VENDOR, 1'b1));
  endtask

  // anar takes the low half of the data word
  task automatic test_anar_write;
    send_access(KIND_WRITE, TARGET_DATA, 32'h1234_ABCD);
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_ANAR, 1'b1));
    send_access(KIND_READ, TARGET_DATA, '0);
  endtask

  // unmodelled address: error on the refresh and on a data read, and a write
  // there still reads back as an error
  task automatic test_unmodelled_regs;
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_FIRST_UNMODELLED, 1'b0));
    send_access(KIND_READ, TARGET_DATA, '0);
    send_access(KIND_WRITE, TARGET_DATA, 32'h0000_5A5A);
    send_access(KIND_WRITE, TARGET_CTRL, ctl_word(PHY_LAST_UNMODELLED, 1'b1));
    send_access(KIND_READ, TARGET_DATA, '0);
  endtask

  // control word extremes: busy bit is never stored
  task automatic test_control_extremes;
    send_access(KIND_WRITE, TARGET_CTRL, 32'hFFFF_FFFF);
    send_access(KIND_READ, TARGET_CTRL, '0);
    send_access(KIND_WRITE, TARGET_CTRL, '0);
    send_access(KIND_READ, TARGET_CTRL, 32'hFFFF_FFFF);
  endtask

  // mostly well-formed data write / control write / data read sequences with
  // random content, plus fully random items and half-finished sequences
  task automatic test_random_traffic;
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] word;
    stop_at = accesses_sent + RANDOM_ITEMS;
    while (accesses_sent < stop_at) begin
      pick                = $urandom_range(0, 9);
      word                = $urandom;
      word[4:0]           = pick_phy_reg();
      word[CTL_WRITE_POS] = ($urandom_range(0, 2) != 0);
      if (pick < 7) begin
        send_access(KIND_WRITE, TARGET_DATA, $urandom);
        send_access(KIND_WRITE, TARGET_CTRL, word);
        send_access(KIND_READ, TARGET_DATA, $urandom);
        if (pick == 0) send_access(KIND_READ, TARGET_CTRL, $urandom);
      end else if (pick < 9) begin
        send_access(1'($urandom), 1'($urandom), $urandom);
      end else begin
        // control write on a stale data word, or a data word never committed
        if ($urandom_range(0, 1) != 0) send_access(KIND_WRITE, TARGET_CTRL, word);
        else send_access(KIND_WRITE, TARGET_DATA, $urandom);
        send_access(KIND_READ, TARGET_DATA, $urandom);
      end
      // occasional full drain in the middle of traffic
      if ($urandom_range(0, 59) == 0) wait_for_results;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults;
    test_bmcr_write;
    test_read_only_regs;
    test_vendor_bit;
    test_anar_write;
    test_unmodelled_regs;
    test_control_extremes;
    // directed part fully settled before random traffic starts
    wait_for_results;
    test_random_traffic;
    wait_for_results;
    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("mdio_phy_register_model_top: match");
    end else begin
      $display("mdio_phy_register_model_top: mismatch");
    end
    $finish;
  end

endmodule
